// ----- hdl/sha1_message_hash_unit_assert.svh -----
// assertion macros used by the checker file
`ifndef SHA1_MESSAGE_HASH_UNIT_ASSERT_SVH
`define SHA1_MESSAGE_HASH_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SHA1MH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha1mh check failed: same-cycle rule");

// next-cycle implication, disabled during reset
`define SHA1MH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha1mh check failed: next-cycle rule");

`endif

// ----- hdl/sha1mh_pkg.sv -----
package sha1mh_pkg;

    // initial chaining value
    localparam logic [31:0] IV_0 = 32'h67452301;
    localparam logic [31:0] IV_1 = 32'hEFCDAB89;
    localparam logic [31:0] IV_2 = 32'h98BADCFE;
    localparam logic [31:0] IV_3 = 32'h10325476;
    localparam logic [31:0] IV_4 = 32'hC3D2E1F0;

    // round constants
    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam logic [5:0] FILL_LAST   = 6'h3f;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam int         WORDS       = 5;
    localparam logic [2:0] WORD_LAST   = 3'd4;

    // source of the byte shifted into the block
    typedef enum logic [1:0] {
        BYTE_MSG,
        BYTE_MARK,
        BYTE_ZERO,
        BYTE_LEN
    } t_byte_sel;

    // round function group
    typedef enum logic [1:0] {
        PH_CHOOSE,
        PH_PARITY_LO,
        PH_MAJORITY,
        PH_PARITY_HI
    } t_phase;

    // controller to datapath commands
    typedef struct packed {
        logic      shift_byte;
        t_byte_sel byte_sel;
        logic [2:0] len_idx;
        logic      latch_tail;
        logic [5:0] tail;
        logic      load_work;
        logic      do_round;
        t_phase    phase;
        logic      fold_cv;
        logic      count_block;
        logic      finish;
        logic      emit_shift;
    } t_cmd;

endpackage

// ----- hdl/sha1mh_in_if.sv -----
interface sha1mh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, message_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, message_byte, byte_present, end_of_message, output ready);
endinterface

// ----- hdl/sha1mh_out_if.sv -----
interface sha1mh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- hdl/sha1_message_hash_unit.sv -----
// SHA-1 hash over a byte stream.
// Input channel i_msg: one transfer per item; message_byte is taken when
// byte_present is set, end_of_message closes the message. An item with
// neither flag set changes nothing.
// Output channel o_digest: five transfers per message, word_index 0 to 4,
// last_word on the fifth; words are big-endian digest words.
// Bytes are taken while the block collects; every 64th byte starts a
// compression (80 rounds plus the chaining update) that holds the input off,
// done by the one-round-per-cycle round unit.
// After the end transfer the partial block is padded (marker, zeros, length)
// and compressed before the first digest word; when it holds 56 bytes or
// more, a second padded block is compressed too; when the end comes with
// the 64th byte of a block, that block's compression comes first.
// Reset: chaining value returns to the initial vector, counts clear, the
// input is held off during reset and ready in the first cycle after it, and
// no digest is pending.
// A stalled receiver holds the current digest word; the next message is
// accepted meanwhile and waits only at its final chaining update.
module sha1_message_hash_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sha1mh_in_if.sink    i_msg,
    sha1mh_out_if.source o_digest
);
    import sha1mh_pkg::*;

    t_cmd cmd;

    // sequencer
    sha1mh_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_msg.valid),
        .i_byte_present   (i_msg.byte_present),
        .i_end_of_message (i_msg.end_of_message),
        .o_in_ready       (i_msg.ready),
        .i_out_ready      (o_digest.ready),
        .o_out_valid      (o_digest.valid),
        .o_word_index     (o_digest.word_index),
        .o_last_word      (o_digest.last_word),
        .o_cmd            (cmd)
    );

    // block buffer, rounds and chaining value
    sha1mh_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_message_byte (i_msg.message_byte),
        .o_digest_word  (o_digest.digest_word)
    );

endmodule

// ----- hdl/sha1mh_ctrl.sv -----
module sha1mh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_byte_present,
    input  logic              i_end_of_message,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [2:0]        o_word_index,
    output logic              o_last_word,
    output sha1mh_pkg::t_cmd  o_cmd
);
    import sha1mh_pkg::*;

    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [6:0] ROUND_G1   = 7'd20;
    localparam logic [6:0] ROUND_G2   = 7'd40;
    localparam logic [6:0] ROUND_G3   = 7'd60;

    typedef enum logic [1:0] {
        S_COLLECT,
        S_PAD,
        S_ROUND,
        S_UPDATE
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_fill, n_fill;
    logic [6:0] r_round, n_round;
    logic       r_end_pend, n_end_pend;
    logic       r_padding, n_padding;
    logic       r_marked, n_marked;
    logic       r_len_ok, n_len_ok;
    logic       r_final, n_final;
    logic       r_emit_busy, n_emit_busy;
    logic [2:0] r_emit_cnt, n_emit_cnt;

    logic       in_xfer;
    logic       out_xfer;
    logic [5:0] fill_next;
    t_cmd       cmd;

    // input closed while reset is held
    assign o_in_ready   = i_rst_n && (r_state == S_COLLECT);
    assign o_out_valid  = r_emit_busy;
    assign o_word_index = r_emit_cnt;
    assign o_last_word  = (r_emit_cnt == WORD_LAST);
    assign o_cmd        = cmd;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign out_xfer  = r_emit_busy && i_out_ready;
    assign fill_next = i_byte_present ? r_fill + 6'd1 : r_fill;

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_round     = r_round;
        n_end_pend  = r_end_pend;
        n_padding   = r_padding;
        n_marked    = r_marked;
        n_len_ok    = r_len_ok;
        n_final     = r_final;
        n_emit_busy = r_emit_busy;
        n_emit_cnt  = r_emit_cnt;
        cmd         = '0;

        unique case (r_state)
            S_COLLECT: begin
                if (in_xfer) begin
                    if (i_byte_present) begin
                        cmd.shift_byte = 1'b1;
                        cmd.byte_sel   = BYTE_MSG;
                        n_fill         = fill_next;
                    end
                    if (i_end_of_message) begin
                        cmd.latch_tail = 1'b1;
                        cmd.tail       = fill_next;
                        n_len_ok       = (fill_next < LEN_POS);
                    end
                    if (i_byte_present && (r_fill == FILL_LAST)) begin
                        // block full: compress before anything else
                        cmd.load_work   = 1'b1;
                        cmd.count_block = 1'b1;
                        n_round         = '0;
                        n_final         = 1'b0;
                        n_end_pend      = i_end_of_message;
                        n_state         = S_ROUND;
                    end else if (i_end_of_message) begin
                        n_padding = 1'b1;
                        n_marked  = 1'b0;
                        n_state   = S_PAD;
                    end
                end
            end
            S_PAD: begin
                // one padding byte per cycle
                cmd.shift_byte = 1'b1;
                if (!r_marked) begin
                    cmd.byte_sel = BYTE_MARK;
                    n_marked     = 1'b1;
                end else if (r_len_ok && (r_fill >= LEN_POS)) begin
                    cmd.byte_sel = BYTE_LEN;
                    cmd.len_idx  = r_fill[2:0];
                end else begin
                    cmd.byte_sel = BYTE_ZERO;
                end
                n_fill = r_fill + 6'd1;
                if (r_fill == FILL_LAST) begin
                    cmd.load_work = 1'b1;
                    n_round       = '0;
                    n_final       = r_len_ok;
                    n_state       = S_ROUND;
                end
            end
            S_ROUND: begin
                cmd.do_round = 1'b1;
                if (r_round < ROUND_G1) begin
                    cmd.phase = PH_CHOOSE;
                end else if (r_round < ROUND_G2) begin
                    cmd.phase = PH_PARITY_LO;
                end else if (r_round < ROUND_G3) begin
                    cmd.phase = PH_MAJORITY;
                end else begin
                    cmd.phase = PH_PARITY_HI;
                end
                n_round = r_round + 7'd1;
                if (r_round == ROUND_LAST) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (r_final) begin
                    // wait until the previous digest has drained
                    if (!r_emit_busy) begin
                        cmd.finish  = 1'b1;
                        n_emit_busy = 1'b1;
                        n_emit_cnt  = '0;
                        n_padding   = 1'b0;
                        n_final     = 1'b0;
                        n_state     = S_COLLECT;
                    end
                end else begin
                    cmd.fold_cv = 1'b1;
                    if (r_padding) begin
                        n_len_ok = 1'b1;
                        n_state  = S_PAD;
                    end else if (r_end_pend) begin
                        n_end_pend = 1'b0;
                        n_padding  = 1'b1;
                        n_marked   = 1'b0;
                        n_state    = S_PAD;
                    end else begin
                        n_state = S_COLLECT;
                    end
                end
            end
            default: n_state = S_COLLECT;
        endcase

        // digest word transfers
        if (out_xfer) begin
            cmd.emit_shift = 1'b1;
            n_emit_cnt     = r_emit_cnt + 3'd1;
            if (r_emit_cnt == WORD_LAST) begin
                n_emit_busy = 1'b0;
            end
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_fill      <= '0;
            r_round     <= '0;
            r_end_pend  <= 1'b0;
            r_padding   <= 1'b0;
            r_marked    <= 1'b0;
            r_len_ok    <= 1'b0;
            r_final     <= 1'b0;
            r_emit_busy <= 1'b0;
            r_emit_cnt  <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_round     <= n_round;
            r_end_pend  <= n_end_pend;
            r_padding   <= n_padding;
            r_marked    <= n_marked;
            r_len_ok    <= n_len_ok;
            r_final     <= n_final;
            r_emit_busy <= n_emit_busy;
            r_emit_cnt  <= n_emit_cnt;
        end
    end

endmodule

// ----- hdl/sha1mh_datapath.sv -----
module sha1mh_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha1mh_pkg::t_cmd  i_cmd,
    input  logic [7:0]        i_message_byte,
    output logic [31:0]       o_digest_word
);
    import sha1mh_pkg::*;

    logic [511:0] r_blk;
    logic [31:0]  r_work [WORDS];
    logic [31:0]  r_cv   [WORDS];
    logic [54:0]  r_blocks;
    logic [5:0]   r_tail;
    logic [159:0] r_digest;

    logic [63:0]  len_bits;
    logic [7:0]   byte_val;
    logic [31:0]  w0, w2, w8, w13, new_w;
    logic [31:0]  f_val, k_val, t_val;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // message length in bits for the last block
    assign len_bits = {r_blocks, r_tail, 3'b000};

    // byte shifted into the block
    always_comb begin
        case (i_cmd.byte_sel)
            BYTE_MSG:  byte_val = i_message_byte;
            BYTE_MARK: byte_val = PAD_MARK;
            BYTE_LEN:  byte_val = len_bits[{3'd7 - i_cmd.len_idx, 3'b000} +: 8];
            default:   byte_val = 8'h00;
        endcase
    end

    // message schedule taps on the sliding window
    assign w0    = r_blk[511:480];
    assign w2    = r_blk[447:416];
    assign w8    = r_blk[255:224];
    assign w13   = r_blk[95:64];
    assign new_w = rotl(w13 ^ w8 ^ w2 ^ w0, 1);

    // round function and constant
    always_comb begin
        case (i_cmd.phase)
            PH_CHOOSE: begin
                f_val = (r_work[1] & r_work[2]) | (~r_work[1] & r_work[3]);
                k_val = K_0;
            end
            PH_PARITY_LO: begin
                f_val = r_work[1] ^ r_work[2] ^ r_work[3];
                k_val = K_1;
            end
            PH_MAJORITY: begin
                f_val = (r_work[1] & r_work[2]) | (r_work[1] & r_work[3]) |
                        (r_work[2] & r_work[3]);
                k_val = K_2;
            end
            default: begin
                f_val = r_work[1] ^ r_work[2] ^ r_work[3];
                k_val = K_3;
            end
        endcase
    end

    assign t_val = rotl(r_work[0], 5) + f_val + r_work[4] + k_val + w0;

    // block buffer, doubles as the schedule window
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_byte) begin
            r_blk <= {r_blk[503:0], byte_val};
        end else if (i_cmd.do_round) begin
            r_blk <= {r_blk[479:0], new_w};
        end
    end

    // working variables a to e
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_work) begin
            for (int i = 0; i < WORDS; i++) begin
                r_work[i] <= r_cv[i];
            end
        end else if (i_cmd.do_round) begin
            r_work[4] <= r_work[3];
            r_work[3] <= r_work[2];
            r_work[2] <= rotl(r_work[1], 30);
            r_work[1] <= r_work[0];
            r_work[0] <= t_val;
        end
    end

    // chaining value and block count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_cv[0]  <= IV_0;
            r_cv[1]  <= IV_1;
            r_cv[2]  <= IV_2;
            r_cv[3]  <= IV_3;
            r_cv[4]  <= IV_4;
            r_blocks <= '0;
        end else begin
            if (i_cmd.fold_cv) begin
                for (int i = 0; i < WORDS; i++) begin
                    r_cv[i] <= r_cv[i] + r_work[i];
                end
            end
            if (i_cmd.count_block) begin
                r_blocks <= r_blocks + 55'd1;
            end
        end
    end

    // tail byte count of the message
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_tail) begin
            r_tail <= i_cmd.tail;
        end
    end

    // digest output register, word 0 on top
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_digest <= {r_cv[0] + r_work[0], r_cv[1] + r_work[1], r_cv[2] + r_work[2],
                         r_cv[3] + r_work[3], r_cv[4] + r_work[4]};
        end else if (i_cmd.emit_shift) begin
            r_digest <= {r_digest[127:0], 32'h0};
        end
    end

    assign o_digest_word = r_digest[159:128];

endmodule

// ----- hdl/sha1mh_checker.sv -----
`include "sha1_message_hash_unit_assert.svh"

module sha1mh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_end_of_message,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_digest_word,
    input logic [2:0]  i_word_index,
    input logic        i_last_word
);

    // stalled digest word holds
    `SHA1MH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_digest_word) && $stable(i_word_index))

    // words of one digest follow in order without gaps
    `SHA1MH_ASSERT_NEXT(a_index_step, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_last_word, i_out_valid && (i_word_index == $past(i_word_index) + 3'd1))

    // last flag marks the fifth word
    `SHA1MH_ASSERT_IMPL(a_last_flag, i_clk, i_rst_n, i_out_valid, i_last_word == (i_word_index == 3'd4))

    // a new digest never starts right after the last word
    `SHA1MH_ASSERT_NEXT(a_gap_after_last, i_clk, i_rst_n, i_out_valid && i_out_ready && i_last_word, !i_out_valid)

    // end of message starts padding or a block compression, input closes
    `SHA1MH_ASSERT_NEXT(a_end_blocks_input, i_clk, i_rst_n, i_in_valid && i_in_ready && i_end_of_message, !i_in_ready)

endmodule

bind sha1_message_hash_unit sha1mh_checker u_sha1mh_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_msg.valid),
    .i_in_ready       (i_msg.ready),
    .i_end_of_message (i_msg.end_of_message),
    .i_out_valid      (o_digest.valid),
    .i_out_ready      (o_digest.ready),
    .i_digest_word    (o_digest.digest_word),
    .i_word_index     (o_digest.word_index),
    .i_last_word      (o_digest.last_word)
);
